FILE: design/blfc_pkg.sv
// Shared types, codes and helper functions for the bootloader link framer/checker.
package blfc_pkg;

  // Input item kinds
  localparam logic [2:0] CMD_INFO    = 3'd0;
  localparam logic [2:0] CMD_SETADDR = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_SETBUF  = 3'd3;
  localparam logic [2:0] CMD_PAYLOAD = 3'd4;
  localparam logic [2:0] CMD_PROGRAM = 3'd5;
  localparam logic [2:0] CMD_RUN     = 3'd6;
  localparam logic [2:0] CMD_RXBYTE  = 3'd7;

  // Result kinds
  localparam logic [1:0] OUT_TX     = 2'd0;
  localparam logic [1:0] OUT_RXDATA = 2'd1;
  localparam logic [1:0] OUT_STATUS = 2'd2;

  // Status codes
  localparam logic [2:0] STS_NONE   = 3'd0;
  localparam logic [2:0] STS_OK     = 3'd1;
  localparam logic [2:0] STS_BADACK = 3'd2;
  localparam logic [2:0] STS_CRCERR = 3'd3;
  localparam logic [2:0] STS_UNEXP  = 3'd4;

  // Expected response modes
  localparam logic [1:0] EXP_NONE = 2'd0;
  localparam logic [1:0] EXP_INFO = 2'd1;
  localparam logic [1:0] EXP_READ = 2'd2;
  localparam logic [1:0] EXP_ACK  = 2'd3;

  // Protocol bytes
  localparam logic [7:0] BYTE_ACK = 8'h30;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Classified item handed from front end to back end
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [8:0]  len;      // normalized block length
    logic [7:0]  data;
    logic        last;
    logic [4:0]  ndata;    // command bytes before the CRC
    logic        has_crc;
  } desc_t;

  // CRC-16, reflected, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Command byte at position idx of a transmit run (before the CRC)
  function automatic logic [7:0] cmd_byte(input desc_t d, input logic [4:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (d.kind)
      CMD_INFO: begin
        if (idx == 5'd8) b = 8'h0D;
        else if (idx == 5'd9) b = 8'h42;
        else if (idx == 5'd16) b = 8'h7D;
      end
      CMD_SETADDR: begin
        if (idx == 5'd0) b = 8'hFF;
        else if (idx == 5'd2) b = d.addr[15:8];
        else if (idx == 5'd3) b = d.addr[7:0];
      end
      CMD_READ: begin
        if (idx == 5'd0) b = 8'h03;
        else b = d.len[7:0];
      end
      CMD_SETBUF: begin
        if (idx == 5'd0) b = 8'hFE;
        else if (idx == 5'd2) b = {7'd0, d.len[8]};
        else if (idx == 5'd3) b = d.len[7:0];
      end
      CMD_PAYLOAD: b = d.data;
      CMD_PROGRAM: begin
        if (idx == 5'd0) b = 8'h01;
      end
      CMD_RUN:    b = 8'h00;
      CMD_RXBYTE: b = d.data;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/blfc_front.sv
// Front end: accepts input items, normalizes lengths and classifies each command.
module blfc_front #(
  parameter int MAX_BLOCK = 256
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           kind_i,
  input  logic [15:0]          addr_i,
  input  logic [8:0]           length_i,
  input  logic [7:0]           data_i,
  input  logic                 end_of_payload_i,
  input  logic                 full_i,
  output logic                 push_o,
  output blfc_pkg::desc_t      desc_o
);

  logic [8:0] len_raw;
  logic [8:0] len_norm;

  // Accept whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Length: mod 256, zero means 256, then clipped to the block limit
  assign len_raw  = (length_i[7:0] == 8'd0) ? 9'd256 : {1'b0, length_i[7:0]};
  assign len_norm = (len_raw > 9'(MAX_BLOCK)) ? 9'(MAX_BLOCK) : len_raw;

  // Classify: run length and CRC presence per command
  always_comb begin
    desc_o.kind    = kind_i;
    desc_o.addr    = addr_i;
    desc_o.len     = len_norm;
    desc_o.data    = data_i;
    desc_o.last    = end_of_payload_i;
    desc_o.ndata   = 5'd0;
    desc_o.has_crc = 1'b0;
    unique case (kind_i)
      blfc_pkg::CMD_INFO:    desc_o.ndata = 5'd17;
      blfc_pkg::CMD_SETADDR: begin
        desc_o.ndata   = 5'd4;
        desc_o.has_crc = 1'b1;
      end
      blfc_pkg::CMD_READ: begin
        desc_o.ndata   = 5'd2;
        desc_o.has_crc = 1'b1;
      end
      blfc_pkg::CMD_SETBUF: begin
        desc_o.ndata   = 5'd4;
        desc_o.has_crc = 1'b1;
      end
      blfc_pkg::CMD_PAYLOAD: begin
        desc_o.ndata   = 5'd1;
        desc_o.has_crc = end_of_payload_i;
      end
      blfc_pkg::CMD_PROGRAM: begin
        desc_o.ndata   = 5'd2;
        desc_o.has_crc = 1'b1;
      end
      blfc_pkg::CMD_RUN:    desc_o.ndata = 5'd4;
      blfc_pkg::CMD_RXBYTE: desc_o.ndata = 5'd0;
      default:              desc_o.ndata = 5'd0;
    endcase
  end

endmodule

FILE: design/blfc_fifo.sv
// Two-entry item queue between front end and back end.
module blfc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  blfc_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output blfc_pkg::desc_t head_o
);

  blfc_pkg::desc_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + 2'd1;
    else if (!do_push && do_pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

FILE: design/blfc_back.sv
// Back end: sequences transmit runs, checks received bytes, drives the result register.
module blfc_back #(
  parameter int INFO_BYTES = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            echo_discard_i,
  input  logic            empty_i,
  input  blfc_pkg::desc_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            run_end_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic            st_q, st_d;
  blfc_pkg::desc_t cur_q, cur_d;
  logic [4:0]      idx_q, idx_d;
  logic [4:0]      total_q, total_d;
  logic [15:0]     run_crc_q, run_crc_d;
  logic            rx_fwd_q, rx_fwd_d;
  logic [2:0]      rx_stat_q, rx_stat_d;

  // Link state
  logic [15:0] tx_crc_q, tx_crc_d;
  logic [8:0]  echo_q, echo_d;
  logic [1:0]  expect_q, expect_d;
  logic [8:0]  rem_q, rem_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        failed_q, failed_d;

  // Result register
  logic        ovld_q, ovld_d;
  logic [1:0]  okind_q, okind_d;
  logic [7:0]  obyte_q, obyte_d;
  logic [2:0]  ostat_q, ostat_d;
  logic        oend_q, oend_d;

  logic        slot_free, fire, is_last;
  logic [7:0]  data_byte;
  logic [15:0] crc_in;
  logic [7:0]  crc_b;
  logic [15:0] crc_nx;
  logic [2:0]  stat_tmp;
  logic        fwd_tmp;

  assign slot_free = !ovld_q || out_ready_i;
  assign fire      = (st_q == ST_BUSY) && slot_free;
  assign is_last   = (idx_q == total_q - 5'd1);
  assign pop_o     = (st_q == ST_IDLE) && !empty_i;
  assign data_byte = blfc_pkg::cmd_byte(cur_q, idx_q);

  // Shared CRC unit: payload/rx update at start, run CRC while sending
  always_comb begin
    if (st_q == ST_IDLE) begin
      crc_in = (head_i.kind == blfc_pkg::CMD_RXBYTE) ? rx_crc_q : tx_crc_q;
      crc_b  = head_i.data;
    end else begin
      crc_in = run_crc_q;
      crc_b  = data_byte;
    end
  end
  assign crc_nx = blfc_pkg::crc_byte(crc_in, crc_b);

  always_comb begin
    st_d      = st_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    total_d   = total_q;
    run_crc_d = run_crc_q;
    rx_fwd_d  = rx_fwd_q;
    rx_stat_d = rx_stat_q;
    tx_crc_d  = tx_crc_q;
    echo_d    = echo_q;
    expect_d  = expect_q;
    rem_d     = rem_q;
    rx_crc_d  = rx_crc_q;
    crc_lo_d  = crc_lo_q;
    failed_d  = failed_q;
    ovld_d    = ovld_q && !out_ready_i;
    okind_d   = okind_q;
    obyte_d   = obyte_q;
    ostat_d   = ostat_q;
    oend_d    = oend_q;
    stat_tmp  = blfc_pkg::STS_NONE;
    fwd_tmp   = 1'b0;

    if (pop_o) begin
      // Start of an item: update expectation, set up the run
      cur_d     = head_i;
      idx_d     = 5'd0;
      run_crc_d = 16'd0;
      total_d   = head_i.ndata + (head_i.has_crc ? 5'd2 : 5'd0);
      unique case (head_i.kind)
        blfc_pkg::CMD_INFO: begin
          expect_d = blfc_pkg::EXP_INFO;
          rem_d    = 9'(INFO_BYTES);
        end
        blfc_pkg::CMD_SETADDR: expect_d = blfc_pkg::EXP_ACK;
        blfc_pkg::CMD_READ: begin
          expect_d = blfc_pkg::EXP_READ;
          rem_d    = head_i.len + 9'd3;
          rx_crc_d = 16'd0;
          failed_d = 1'b0;
        end
        blfc_pkg::CMD_SETBUF: begin
          expect_d = blfc_pkg::EXP_NONE;
          tx_crc_d = 16'd0;
        end
        blfc_pkg::CMD_PAYLOAD: begin
          run_crc_d = crc_nx;
          tx_crc_d  = head_i.last ? 16'd0 : crc_nx;
          expect_d  = head_i.last ? blfc_pkg::EXP_ACK : blfc_pkg::EXP_NONE;
        end
        blfc_pkg::CMD_PROGRAM: expect_d = blfc_pkg::EXP_ACK;
        blfc_pkg::CMD_RUN:     expect_d = blfc_pkg::EXP_NONE;
        blfc_pkg::CMD_RXBYTE: begin
          // Received byte: echo drop, then check against the expectation
          if (echo_discard_i && echo_q != 9'd0) begin
            echo_d = echo_q - 9'd1;
          end else begin
            unique case (expect_q)
              blfc_pkg::EXP_INFO: begin
                fwd_tmp = 1'b1;
                rem_d   = (rem_q != 9'd0) ? rem_q - 9'd1 : 9'd0;
                if (rem_q <= 9'd1) begin
                  stat_tmp = blfc_pkg::STS_OK;
                  expect_d = blfc_pkg::EXP_NONE;
                end
              end
              blfc_pkg::EXP_READ: begin
                if (rem_q > 9'd3) begin
                  fwd_tmp  = 1'b1;
                  rx_crc_d = crc_nx;
                  rem_d    = rem_q - 9'd1;
                end else if (rem_q == 9'd3) begin
                  crc_lo_d = head_i.data;
                  rem_d    = rem_q - 9'd1;
                end else if (rem_q == 9'd2) begin
                  failed_d = ({head_i.data, crc_lo_q} != rx_crc_q);
                  rem_d    = rem_q - 9'd1;
                end else begin
                  if (head_i.data != blfc_pkg::BYTE_ACK) stat_tmp = blfc_pkg::STS_BADACK;
                  else if (failed_q) stat_tmp = blfc_pkg::STS_CRCERR;
                  else stat_tmp = blfc_pkg::STS_OK;
                  rem_d    = 9'd0;
                  expect_d = blfc_pkg::EXP_NONE;
                end
              end
              blfc_pkg::EXP_ACK: begin
                stat_tmp = (head_i.data == blfc_pkg::BYTE_ACK) ? blfc_pkg::STS_OK
                                                               : blfc_pkg::STS_BADACK;
                expect_d = blfc_pkg::EXP_NONE;
              end
              default: stat_tmp = blfc_pkg::STS_UNEXP;
            endcase
          end
          total_d = {4'd0, fwd_tmp} + ((stat_tmp != blfc_pkg::STS_NONE) ? 5'd1 : 5'd0);
        end
        default: expect_d = expect_q;
      endcase
      rx_fwd_d  = fwd_tmp;
      rx_stat_d = stat_tmp;
      st_d      = (total_d != 5'd0) ? ST_BUSY : ST_IDLE;
    end else if (fire) begin
      // One result per cycle into the output register, while the register is free
      ovld_d = 1'b1;
      oend_d = is_last;
      if (cur_q.kind == blfc_pkg::CMD_RXBYTE) begin
        if (idx_q == 5'd0 && rx_fwd_q) begin
          okind_d = blfc_pkg::OUT_RXDATA;
          obyte_d = cur_q.data;
          ostat_d = blfc_pkg::STS_NONE;
        end else begin
          okind_d = blfc_pkg::OUT_STATUS;
          obyte_d = 8'd0;
          ostat_d = rx_stat_q;
        end
      end else begin
        okind_d = blfc_pkg::OUT_TX;
        ostat_d = blfc_pkg::STS_NONE;
        if (idx_q < cur_q.ndata) begin
          obyte_d = data_byte;
          if (cur_q.kind != blfc_pkg::CMD_PAYLOAD) run_crc_d = crc_nx;
        end else if (idx_q == cur_q.ndata) begin
          obyte_d = run_crc_q[7:0];
        end else begin
          obyte_d = run_crc_q[15:8];
        end
        if (echo_discard_i && echo_q != 9'd511) echo_d = echo_q + 9'd1;
      end
      idx_d = idx_q + 5'd1;
      if (is_last) st_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      idx_q    <= 5'd0;
      total_q  <= 5'd0;
      tx_crc_q <= 16'd0;
      echo_q   <= 9'd0;
      expect_q <= blfc_pkg::EXP_NONE;
      rem_q    <= 9'd0;
      rx_crc_q <= 16'd0;
      crc_lo_q <= 8'd0;
      failed_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      total_q  <= total_d;
      tx_crc_q <= tx_crc_d;
      echo_q   <= echo_d;
      expect_q <= expect_d;
      rem_q    <= rem_d;
      rx_crc_q <= rx_crc_d;
      crc_lo_q <= crc_lo_d;
      failed_q <= failed_d;
      ovld_q   <= ovld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    run_crc_q <= run_crc_d;
    rx_fwd_q  <= rx_fwd_d;
    rx_stat_q <= rx_stat_d;
    okind_q   <= okind_d;
    obyte_q   <= obyte_d;
    ostat_q   <= ostat_d;
    oend_q    <= oend_d;
  end

  assign out_valid_o = ovld_q;
  assign out_kind_o  = okind_q;
  assign out_byte_o  = obyte_q;
  assign status_o    = ostat_q;
  assign run_end_o   = oend_q;

endmodule

FILE: design/bootloader_link_framer_checker_top.sv
// Top level of the bootloader link framer/checker: front end, item queue, back end.
// Turns command items into transmit byte runs (CRC-16 0xA001 appended where the
// protocol needs it) and checks received bytes against the pending response,
// dropping loopback echo while echo_discard is set. Input items are taken every
// cycle while the two-entry queue has room. The back end handles one item at a
// time: it picks the item up, then issues its results one after another, so a received
// byte yields up to two results, a payload byte one or three, the info probe 17. The result
// register frees each cycle the consumer takes its item. No clearing pass after reset.
module bootloader_link_framer_checker_top #(
  parameter int INFO_BYTES = 9,
  parameter int MAX_BLOCK  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] addr_i,
  input  logic [8:0]  length_i,
  input  logic [7:0]  data_i,
  input  logic        end_of_payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        run_end_o
);

  logic            echo_discard_q;
  logic            full, empty, push, pop;
  blfc_pkg::desc_t push_desc, head_desc;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_discard_q <= 1'b1;
    end else if (cfg_valid_i) begin
      echo_discard_q <= cfg_data_i;
    end
  end

  blfc_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .addr_i           (addr_i),
    .length_i         (length_i),
    .data_i           (data_i),
    .end_of_payload_i (end_of_payload_i),
    .full_i           (full),
    .push_o           (push),
    .desc_o           (push_desc)
  );

  blfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_desc)
  );

  blfc_back #(
    .INFO_BYTES (INFO_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .echo_discard_i (echo_discard_q),
    .empty_i        (empty),
    .head_i         (head_desc),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .run_end_o      (run_end_o)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the bootloader link framer/checker top level.
`timescale 1ns / 100ps

module tb_top;

  localparam int INFO_BYTES  = 9;
  localparam int MAX_BLOCK   = 256;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_TAIL   = 30;
  localparam int LIMIT       = 400000;

  // Command opcodes at the head of each transmit run
  localparam logic [7:0] OP_SETADDR = 8'hFF;
  localparam logic [7:0] OP_SETBUF  = 8'hFE;
  localparam logic [7:0] OP_READ    = 8'h03;
  localparam logic [7:0] OP_PROGRAM = 8'h01;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [8:0]  length;
    logic [7:0]  data;
    logic        eop;
  } link_cmd_t;

  typedef struct packed {
    logic [1:0] rkind;
    logic [7:0] rbyte;
    logic [2:0] rstatus;
    logic       rend;
  } link_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] kind = '0;
  logic [15:0] addr = '0;
  logic [8:0] length = '0;
  logic [7:0] data = '0;
  logic eop = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic run_end;

  bootloader_link_framer_checker_top DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .addr_i           (addr),
    .length_i         (length),
    .data_i           (data),
    .end_of_payload_i (eop),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_kind_o       (out_kind),
    .out_byte_o       (out_byte),
    .status_o         (status),
    .run_end_o        (run_end)
  );

  always #5 clk = ~clk;

  // Shared test state
  link_cmd_t cmd_backlog[$];
  link_res_t pending_results[$];
  link_cmd_t drv_item;
  link_res_t obs_res;
  link_res_t exp_res;
  int send_idle_pct = 26;
  int recv_stall_pct = 52;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int checked = 0;
  int stim_items = 0;
  int cycle_cnt = 0;

  // Predictor state
  logic       echo_drop_en = 1'b1;
  logic [15:0] pl_crc = '0;
  logic [8:0] echo_pending = '0;
  logic [1:0] resp_mode = blfc_pkg::EXP_NONE;
  logic [8:0] resp_left = '0;
  logic [15:0] rd_crc = '0;
  logic [7:0] rd_crc_lo = '0;
  logic       rd_crc_bad = 1'b0;

  // Stimulus-side mirror of the echo counter, used to build clean exchanges
  bit gen_echo_on = 1'b1;
  int gen_echo_cnt = 0;

  // CRC-16/ARC, one byte, LSB first
  function automatic logic [15:0] crc16_arc(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ b[i]) ? ((r >> 1) ^ blfc_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Block length: 0 means 256, capped at the largest block
  function automatic logic [8:0] block_len(input logic [8:0] len);
    logic [8:0] n;
    n = (len[7:0] == 8'd0) ? 9'd256 : {1'b0, len[7:0]};
    if (n > MAX_BLOCK) n = 9'(MAX_BLOCK);
    return n;
  endfunction

  task automatic emit_result(input logic [1:0] k, input logic [7:0] b, input logic [2:0] s);
    link_res_t r;
    r.rkind = k;
    r.rbyte = b;
    r.rstatus = s;
    r.rend = 1'b0;
    pending_results.push_back(r);
  endtask

  task automatic emit_tx(input logic [7:0] b);
    emit_result(blfc_pkg::OUT_TX, b, blfc_pkg::STS_NONE);
    if (echo_drop_en && echo_pending < 9'd511) echo_pending++;
  endtask

  // Up to four command bytes, MSB first, optionally followed by their CRC
  task automatic emit_framed(input logic [31:0] bytes, input int nb, input bit with_crc);
    logic [15:0] c;
    logic [7:0] b;
    c = '0;
    for (int i = 0; i < nb; i++) begin
      b = bytes[31-8*i -: 8];
      emit_tx(b);
      c = crc16_arc(c, b);
    end
    if (with_crc) begin
      emit_tx(c[7:0]);
      emit_tx(c[15:8]);
    end
  endtask

  // Received byte: echo drop, then match against the pending response
  task automatic predict_rx(input logic [7:0] b);
    if (echo_drop_en && echo_pending != 0) begin
      echo_pending--;
    end else if (resp_mode == blfc_pkg::EXP_INFO) begin
      emit_result(blfc_pkg::OUT_RXDATA, b, blfc_pkg::STS_NONE);
      if (resp_left != 0) resp_left--;
      if (resp_left == 0) begin
        emit_result(blfc_pkg::OUT_STATUS, 8'h00, blfc_pkg::STS_OK);
        resp_mode = blfc_pkg::EXP_NONE;
      end
    end else if (resp_mode == blfc_pkg::EXP_READ) begin
      if (resp_left > 3) begin
        emit_result(blfc_pkg::OUT_RXDATA, b, blfc_pkg::STS_NONE);
        rd_crc = crc16_arc(rd_crc, b);
        resp_left--;
      end else if (resp_left == 3) begin
        rd_crc_lo = b;
        resp_left--;
      end else if (resp_left == 2) begin
        rd_crc_bad = ({b, rd_crc_lo} != rd_crc);
        resp_left--;
      end else begin
        emit_result(blfc_pkg::OUT_STATUS, 8'h00,
                    (b != blfc_pkg::BYTE_ACK) ? blfc_pkg::STS_BADACK :
                    (rd_crc_bad ? blfc_pkg::STS_CRCERR : blfc_pkg::STS_OK));
        resp_left = '0;
        resp_mode = blfc_pkg::EXP_NONE;
      end
    end else if (resp_mode == blfc_pkg::EXP_ACK) begin
      emit_result(blfc_pkg::OUT_STATUS, 8'h00,
                  (b == blfc_pkg::BYTE_ACK) ? blfc_pkg::STS_OK : blfc_pkg::STS_BADACK);
      resp_mode = blfc_pkg::EXP_NONE;
    end else begin
      emit_result(blfc_pkg::OUT_STATUS, 8'h00, blfc_pkg::STS_UNEXP);
    end
  endtask

  // Expected results of one accepted item
  task automatic predict_link_item(input link_cmd_t c);
    int base;
    logic [8:0] n;
    link_res_t r;
    base = pending_results.size();
    n = block_len(c.length);
    case (c.kind)
      blfc_pkg::CMD_INFO: begin
        for (int i = 0; i < 17; i++) begin
          case (i)
            8: emit_tx(8'h0D);
            9: emit_tx(8'h42);
            16: emit_tx(8'h7D);
            default: emit_tx(8'h00);
          endcase
        end
        resp_mode = blfc_pkg::EXP_INFO;
        resp_left = 9'(INFO_BYTES);
      end
      blfc_pkg::CMD_SETADDR: begin
        emit_framed({OP_SETADDR, 8'h00, c.addr}, 4, 1'b1);
        resp_mode = blfc_pkg::EXP_ACK;
      end
      blfc_pkg::CMD_READ: begin
        emit_framed({OP_READ, n[7:0], 16'h0000}, 2, 1'b1);
        resp_mode = blfc_pkg::EXP_READ;
        resp_left = n + 9'd3;
        rd_crc = '0;
        rd_crc_bad = 1'b0;
      end
      blfc_pkg::CMD_SETBUF: begin
        emit_framed({OP_SETBUF, 8'h00, 7'd0, n[8], n[7:0]}, 4, 1'b1);
        resp_mode = blfc_pkg::EXP_NONE;
        pl_crc = '0;
      end
      blfc_pkg::CMD_PAYLOAD: begin
        emit_tx(c.data);
        pl_crc = crc16_arc(pl_crc, c.data);
        if (c.eop) begin
          emit_tx(pl_crc[7:0]);
          emit_tx(pl_crc[15:8]);
          pl_crc = '0;
          resp_mode = blfc_pkg::EXP_ACK;
        end else begin
          resp_mode = blfc_pkg::EXP_NONE;
        end
      end
      blfc_pkg::CMD_PROGRAM: begin
        emit_framed({OP_PROGRAM, 8'h00, 16'h0000}, 2, 1'b1);
        resp_mode = blfc_pkg::EXP_ACK;
      end
      blfc_pkg::CMD_RUN: begin
        emit_framed(32'h0, 4, 1'b0);
        resp_mode = blfc_pkg::EXP_NONE;
      end
      default: predict_rx(c.data);
    endcase
    // Flag the last result of this item
    if (pending_results.size() > base) begin
      r = pending_results.pop_back();
      r.rend = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // Driver: presents queued items, predicts on acceptance
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      kind <= '0;
      addr <= '0;
      length <= '0;
      data <= '0;
      eop <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_link_item(drv_item);
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          kind <= drv_item.kind;
          addr <= drv_item.addr;
          length <= drv_item.length;
          data <= drv_item.data;
          eop <= drv_item.eop;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls, long hold on request, checks each result
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        obs_res = '{out_kind, out_byte, status, run_end};
        checked++;
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected: kind %0d byte %02h status %0d end %0d",
                   $time, out_kind, out_byte, status, run_end);
        end else begin
          exp_res = pending_results.pop_front();
          if (obs_res !== exp_res) begin
            err_cnt++;
            $display("%0t: mismatch: expected kind/byte/status/end %0d/%02h/%0d/%0d",
                     $time, exp_res.rkind, exp_res.rbyte, exp_res.rstatus, exp_res.rend);
            $display("%0t:           actual   kind/byte/status/end %0d/%02h/%0d/%0d",
                     $time, out_kind, out_byte, status, run_end);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
      $display("[bootloader_link_framer_checker_top] ERROR");
      $finish;
    end
  end

  // Queue one item and track the echo count it leaves behind
  task automatic queue_cmd(input logic [2:0] k, input logic [15:0] a, input logic [8:0] len,
                           input logic [7:0] d, input logic e);
    link_cmd_t c;
    int ntx;
    c = '{k, a, len, d, e};
    while (cmd_backlog.size() >= 48) @(negedge clk);
    cmd_backlog.push_back(c);
    case (k)
      blfc_pkg::CMD_INFO: ntx = 17;
      blfc_pkg::CMD_SETADDR, blfc_pkg::CMD_SETBUF: ntx = 6;
      blfc_pkg::CMD_READ, blfc_pkg::CMD_PROGRAM, blfc_pkg::CMD_RUN: ntx = 4;
      blfc_pkg::CMD_PAYLOAD: ntx = e ? 3 : 1;
      default: ntx = 0;
    endcase
    if (k == blfc_pkg::CMD_RXBYTE && gen_echo_on && gen_echo_cnt > 0) gen_echo_cnt--;
    stim_items++;
    for (int i = 0; i < ntx; i++) begin
      if (gen_echo_on && gen_echo_cnt < 511) gen_echo_cnt++;
    end
  endtask

  task automatic rx_byte(input logic [7:0] d);
    queue_cmd(blfc_pkg::CMD_RXBYTE, 16'($urandom), 9'($urandom_range(1, 256)), d,
              1'($urandom));
  endtask

  task automatic simple_cmd(input logic [2:0] k);
    queue_cmd(k, 16'($urandom), 9'($urandom_range(1, 256)), 8'($urandom), 1'($urandom));
  endtask

  // Line loopback: one received copy per transmitted byte
  task automatic flush_echo();
    while (gen_echo_on && gen_echo_cnt > 0) rx_byte(8'($urandom));
  endtask

  task automatic ack_byte();
    rx_byte(($urandom_range(99) < 85) ? blfc_pkg::BYTE_ACK : 8'($urandom));
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (IDLE_TAIL) @(negedge clk);
  endtask

  task automatic write_echo_cfg(input bit v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    echo_drop_en = v;
    gen_echo_on = v;
    @(negedge clk);
  endtask

  // One command/response exchange with random content, or line noise
  task automatic random_exchange();
    int sel;
    int cnt;
    int r;
    logic [8:0] n;
    logic [15:0] c;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 14) begin
      simple_cmd(blfc_pkg::CMD_INFO);
      flush_echo();
      cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : INFO_BYTES;
      repeat (cnt) rx_byte(8'($urandom));
    end else if (sel < 28) begin
      queue_cmd(blfc_pkg::CMD_SETADDR, ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
                9'($urandom_range(1, 256)), 8'($urandom), 1'($urandom));
      flush_echo();
      ack_byte();
    end else if (sel < 48 || (sel >= 76 && sel < 84)) begin
      r = $urandom_range(99);
      n = (r < 3) ? 9'd256 : (r < 5) ? 9'd255 : 9'($urandom_range(1, 8));
      queue_cmd(blfc_pkg::CMD_READ, 16'($urandom), n, 8'($urandom), 1'($urandom));
      flush_echo();
      c = '0;
      // Short response: a later command overrides the expectation
      cnt = (sel >= 76) ? $urandom_range(0, n + 2) : n + 3;
      for (int i = 0; i < n && cnt > 0; i++) begin
        b = 8'($urandom);
        c = crc16_arc(c, b);
        rx_byte(b);
        cnt--;
      end
      lo = c[7:0];
      hi = c[15:8];
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(1)) lo ^= 8'(1 << $urandom_range(7));
        else hi ^= 8'(1 << $urandom_range(7));
      end
      if (cnt > 0) begin rx_byte(lo); cnt--; end
      if (cnt > 0) begin rx_byte(hi); cnt--; end
      if (cnt > 0) ack_byte();
    end else if (sel < 66) begin
      queue_cmd(blfc_pkg::CMD_SETBUF, 16'($urandom),
                ($urandom_range(9) == 0) ? 9'd256 : 9'($urandom_range(1, 8)),
                8'($urandom), 1'($urandom));
      cnt = $urandom_range(1, 6);
      for (int i = 0; i < cnt; i++) begin
        queue_cmd(blfc_pkg::CMD_PAYLOAD, 16'($urandom), 9'($urandom_range(1, 256)),
                  8'($urandom), (i == cnt - 1) ? ($urandom_range(9) != 0) : 1'b0);
      end
      flush_echo();
      ack_byte();
    end else if (sel < 74) begin
      simple_cmd(blfc_pkg::CMD_PROGRAM);
      flush_echo();
      ack_byte();
    end else if (sel < 76) begin
      simple_cmd(blfc_pkg::CMD_RUN);
      flush_echo();
    end else begin
      cnt = $urandom_range(1, 3);
      repeat (cnt) begin
        if ($urandom_range(1)) rx_byte(8'($urandom));
        else simple_cmd(3'($urandom_range(0, 6)));
      end
    end
  endtask

  initial begin
    logic [15:0] c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with the echo drop off
    write_echo_cfg(1'b0);
    rx_byte(8'h00);                       // nothing pending
    simple_cmd(blfc_pkg::CMD_INFO);
    rx_byte(8'h00);
    rx_byte(8'hFF);
    repeat (INFO_BYTES - 2) rx_byte(8'($urandom));
    queue_cmd(blfc_pkg::CMD_SETADDR, 16'hFFFF, 9'd1, 8'h00, 1'b0);
    rx_byte(blfc_pkg::BYTE_ACK);
    queue_cmd(blfc_pkg::CMD_SETADDR, 16'h0000, 9'd256, 8'hFF, 1'b1);
    rx_byte(8'hFF);                       // bad ack
    queue_cmd(blfc_pkg::CMD_READ, 16'h1234, 9'd1, 8'h00, 1'b0);
    rx_byte(8'hA5);
    c = crc16_arc(16'h0000, 8'hA5);
    rx_byte(~c[7:0]);                     // corrupted CRC
    rx_byte(c[15:8]);
    rx_byte(blfc_pkg::BYTE_ACK);
    queue_cmd(blfc_pkg::CMD_SETBUF, 16'h0000, 9'd256, 8'h00, 1'b0);
    queue_cmd(blfc_pkg::CMD_PAYLOAD, 16'hFFFF, 9'd255, 8'hFF, 1'b1);
    rx_byte(blfc_pkg::BYTE_ACK);
    simple_cmd(blfc_pkg::CMD_PROGRAM);
    simple_cmd(blfc_pkg::CMD_RUN);
    wait_idle();

    // Echo drop on, sender idles lightly, receiver heavily
    write_echo_cfg(1'b1);
    while (stim_items < 150) random_exchange();
    simple_cmd(blfc_pkg::CMD_RUN);        // leave echo count behind
    wait_idle();

    // Echo drop off with a stale count, idling swapped
    write_echo_cfg(1'b0);
    send_idle_pct = 52;
    recv_stall_pct = 26;
    while (stim_items < 225) random_exchange();
    wait_idle();                          // sender waits for a full drain
    while (stim_items < 300) random_exchange();
    wait_idle();

    // Echo drop back on, no idling; then a long output stall that saturates the echo count
    write_echo_cfg(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (stim_items < 430) random_exchange();
    hold_req++;
    repeat (31) simple_cmd(blfc_pkg::CMD_INFO);
    wait_idle();

    if (pending_results.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Run covered %0d items and %0d checked results: all commands, info/read/ack",
             stim_items, checked);
    $display("responses, echo drop on and off with saturation, stalls and drain pauses.");
    if (err_cnt == 0) begin
      $display("[bootloader_link_framer_checker_top] OK");
    end else begin
      $display("[bootloader_link_framer_checker_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
design/blfc_pkg.sv
design/blfc_front.sv
design/blfc_fifo.sv
design/blfc_back.sv
design/bootloader_link_framer_checker_top.sv
tb/tb_top.sv
